@@ rtl/nnsa_pkg.sv @@
// ----------------------------------------------------------------------------
// nnsa_pkg
// Types and constants for the nearest-neighbour scale addresser.
// ----------------------------------------------------------------------------
package nnsa_pkg;

    localparam int unsigned COORD_W    = 12;
    localparam int unsigned DIM_W      = 13;
    localparam int unsigned PITCH_W    = 20;
    localparam int unsigned ADDR_W     = 32;
    localparam int unsigned PROD_W     = COORD_W + DIM_W;     // d*src
    localparam int unsigned WORDS_W    = ADDR_W - 2;          // 4 bytes per pixel
    localparam int unsigned CFG_DATA_W = 32;
    localparam int unsigned COORD_MAX  = 4095;

    typedef enum logic [2:0] {
        CFG_SOURCE_WIDTH  = 3'd0,
        CFG_SOURCE_HEIGHT = 3'd1,
        CFG_TARGET_WIDTH  = 3'd2,
        CFG_TARGET_HEIGHT = 3'd3,
        CFG_SOURCE_PITCH  = 3'd4,
        CFG_TARGET_PITCH  = 3'd5,
        CFG_SOURCE_BASE   = 3'd6,
        CFG_TARGET_BASE   = 3'd7
    } t_cfg_idx;

    typedef struct packed {
        logic [COORD_W-1:0] out_x;
        logic [COORD_W-1:0] out_y;
    } t_in_word;

    typedef struct packed {
        logic [COORD_W-1:0] in_x;
        logic [COORD_W-1:0] in_y;
        logic [ADDR_W-1:0]  read_address;
        logic [ADDR_W-1:0]  write_address;
        logic               out_of_range;
    } t_out_word;

    // one pipeline stage; fields are filled in as the word moves down
    typedef struct packed {
        logic [COORD_W-1:0] ox;
        logic [COORD_W-1:0] oy;
        logic               oor;
        logic [PROD_W-1:0]  rx;      // product, then partial remainder
        logic [PROD_W-1:0]  ry;
        logic [COORD_W-1:0] qx;      // quotient, then source coordinate
        logic [COORD_W-1:0] qy;
        logic               satx;
        logic               saty;
        logic [WORDS_W-1:0] wlin;    // destination word offset
        logic [ADDR_W-1:0]  waddr;
        logic [WORDS_W-1:0] rlin;    // source row word offset
        logic [ADDR_W-1:0]  raddr;
    } t_stg;

endpackage

@@ rtl/nearest_neighbor_scale_addresser.sv @@
// Nearest-neighbour scale addresser: one destination pixel word enters per
// clock unless the pipeline is stalled, and results leave one per clock when
// the output side keeps up. The pipeline is built around the two quotient
// dividers (d*src/dst on each axis), restoring dividers unrolled into six
// stages of two quotient bits each, plus a multiply stage and a quotient
// overflow check in front and the saturation, source row multiply and
// address add behind. Empty stages close up under back-pressure, so the
// input stays ready while any stage holds a bubble.
// ----------------------------------------------------------------------------
// nearest_neighbor_scale_addresser
// Maps destination coordinates to nearest-neighbour source coordinates and
// forms the source and destination byte addresses.
// ----------------------------------------------------------------------------
module nearest_neighbor_scale_addresser #(
    parameter int MAX_DIM = 4096
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  nnsa_pkg::t_cfg_idx             i_cfg_idx,
    input  logic [nnsa_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  nnsa_pkg::t_in_word             i_data,
    output logic                           o_valid,
    input  logic                           i_ready,
    output nnsa_pkg::t_out_word            o_data
);
    import nnsa_pkg::*;

    localparam int NSTG = 11;
    localparam int unsigned LIM_I =
        (MAX_DIM - 1 > COORD_MAX) ? COORD_MAX : MAX_DIM - 1;
    localparam logic [COORD_W-1:0] LIM = COORD_W'(LIM_I);

    logic [DIM_W-1:0]   r_src_w, r_src_h, r_tgt_w, r_tgt_h;
    logic [PITCH_W-1:0] r_src_pitch, r_tgt_pitch;
    logic [ADDR_W-1:0]  r_src_base, r_tgt_base;

    logic [NSTG-1:0] r_vld;
    logic [NSTG-1:0] stg_rdy;
    t_stg            r_stg [NSTG];
    t_stg            n_stg [NSTG];

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_w     <= DIM_W'(1);
            r_src_h     <= DIM_W'(1);
            r_tgt_w     <= DIM_W'(1);
            r_tgt_h     <= DIM_W'(1);
            r_src_pitch <= '0;
            r_tgt_pitch <= '0;
            r_src_base  <= '0;
            r_tgt_base  <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_SOURCE_WIDTH:  r_src_w     <= i_cfg_data[DIM_W-1:0];
                CFG_SOURCE_HEIGHT: r_src_h     <= i_cfg_data[DIM_W-1:0];
                CFG_TARGET_WIDTH:  r_tgt_w     <= i_cfg_data[DIM_W-1:0];
                CFG_TARGET_HEIGHT: r_tgt_h     <= i_cfg_data[DIM_W-1:0];
                CFG_SOURCE_PITCH:  r_src_pitch <= i_cfg_data[PITCH_W-1:0];
                CFG_TARGET_PITCH:  r_tgt_pitch <= i_cfg_data[PITCH_W-1:0];
                CFG_SOURCE_BASE:   r_src_base  <= i_cfg_data[ADDR_W-1:0];
                CFG_TARGET_BASE:   r_tgt_base  <= i_cfg_data[ADDR_W-1:0];
                default: ;
            endcase
        end
    end

    // two restoring steps per stage, quotient bits hi and hi-1
    function automatic t_stg div_stage(t_stg s, logic [DIM_W-1:0] dw,
                                       logic [DIM_W-1:0] dh, int hi);
        logic [PROD_W-1:0]          dx;
        logic [PROD_W-1:0]          dy;
        logic [$clog2(COORD_W)-1:0] b;
        for (int j = 0; j < 2; j++) begin
            b  = ($clog2(COORD_W))'(hi - j);
            dx = PROD_W'(dw) << b;
            dy = PROD_W'(dh) << b;
            if (s.rx >= dx) begin
                s.rx    = s.rx - dx;
                s.qx[b] = 1'b1;
            end
            if (s.ry >= dy) begin
                s.ry    = s.ry - dy;
                s.qy[b] = 1'b1;
            end
        end
        return s;
    endfunction

    always_comb begin
        // stage 0: products and range flag
        n_stg[0]      = '0;
        n_stg[0].ox   = i_data.out_x;
        n_stg[0].oy   = i_data.out_y;
        n_stg[0].oor  = (DIM_W'(i_data.out_x) >= r_tgt_w) ||
                        (DIM_W'(i_data.out_y) >= r_tgt_h);
        n_stg[0].rx   = PROD_W'(i_data.out_x) * PROD_W'(r_src_w);
        n_stg[0].ry   = PROD_W'(i_data.out_y) * PROD_W'(r_src_h);
        n_stg[0].wlin = WORDS_W'(i_data.out_y) * WORDS_W'(r_tgt_pitch[PITCH_W-1:2]);

        // stage 1: quotient overflow check, destination word offset
        n_stg[1]      = r_stg[0];
        n_stg[1].qx   = '0;
        n_stg[1].qy   = '0;
        n_stg[1].satx = r_stg[0].rx >= {r_tgt_w, {COORD_W{1'b0}}};
        n_stg[1].saty = r_stg[0].ry >= {r_tgt_h, {COORD_W{1'b0}}};
        n_stg[1].wlin = r_stg[0].wlin + WORDS_W'(r_stg[0].ox);

        // stages 2..7: division, bits 11 down to 0
        for (int k = 2; k <= 7; k++) begin
            n_stg[k] = div_stage(r_stg[k-1], r_tgt_w, r_tgt_h, 15 - 2 * k);
        end
        n_stg[2].waddr = r_tgt_base + {r_stg[1].wlin, 2'b00};

        // stage 8: zero divisor and saturation
        n_stg[8] = r_stg[7];
        if (r_tgt_w == '0) begin
            n_stg[8].qx = '0;
        end else if (r_stg[7].satx || r_stg[7].qx > LIM) begin
            n_stg[8].qx = LIM;
        end
        if (r_tgt_h == '0) begin
            n_stg[8].qy = '0;
        end else if (r_stg[7].saty || r_stg[7].qy > LIM) begin
            n_stg[8].qy = LIM;
        end

        // stage 9: source row offset
        n_stg[9]      = r_stg[8];
        n_stg[9].rlin = WORDS_W'(r_stg[8].qy) * WORDS_W'(r_src_pitch[PITCH_W-1:2]);

        // stage 10: source address
        n_stg[10]       = r_stg[9];
        n_stg[10].raddr = r_src_base +
                          {r_stg[9].rlin + WORDS_W'(r_stg[9].qx), 2'b00};
    end

    // a stage takes a new word when it is empty or its word moves on
    always_comb begin
        stg_rdy[NSTG-1] = !r_vld[NSTG-1] || i_ready;
        for (int k = NSTG - 2; k >= 0; k--) begin
            stg_rdy[k] = !r_vld[k] || stg_rdy[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (stg_rdy[0]) r_vld[0] <= i_valid;
            for (int k = 1; k < NSTG; k++) begin
                if (stg_rdy[k]) r_vld[k] <= r_vld[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < NSTG; k++) begin
            if (stg_rdy[k]) r_stg[k] <= n_stg[k];
        end
    end

    assign o_ready = stg_rdy[0];
    assign o_valid = r_vld[NSTG-1];

    always_comb begin
        o_data.in_x          = r_stg[NSTG-1].qx;
        o_data.in_y          = r_stg[NSTG-1].qy;
        o_data.read_address  = r_stg[NSTG-1].raddr;
        o_data.write_address = r_stg[NSTG-1].waddr;
        o_data.out_of_range  = r_stg[NSTG-1].oor;
    end

    a_rst_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> !o_valid)
        else $error("output valid straight after reset");

    a_take_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> r_vld[0])
        else $error("accepted word missing from first stage");

    a_full_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> (&r_vld) && !i_ready)
        else $error("input stalled with a bubble in the pipeline");

    a_coord_lim: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_data.in_x <= LIM && o_data.in_y <= LIM)
        else $error("source coordinate above limit");

endmodule

@@ tb/tb_nearest_neighbor_scale_addresser.sv @@
// ----------------------------------------------------------------------------
// tb_nearest_neighbor_scale_addresser
// Self-checking bench for the nearest-neighbour scale addresser. A queue-fed
// driver offers destination coordinates. A monitor predicts the source
// coordinate, both byte addresses and the range flag for every accepted word,
// then checks each output word against the oldest prediction. Register
// settings change between phases while the block is empty. Sender gaps and
// receiver stalls vary from phase to phase.
// ----------------------------------------------------------------------------
module tb_nearest_neighbor_scale_addresser;
    import nnsa_pkg::*;

    localparam int unsigned WATCHDOG_LIMIT = 2000;
    localparam int unsigned LONG_HOLD      = 300;
    localparam int unsigned DRAIN_CYCLES   = 20;
    localparam int unsigned ITEMS_PER_PHASE = 190;

    logic                  i_clk      = 1'b0;
    logic                  i_rst_n    = 1'b0;
    logic                  i_cfg_we   = 1'b0;
    t_cfg_idx              i_cfg_idx  = CFG_SOURCE_WIDTH;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  i_valid    = 1'b0;
    logic                  o_ready;
    t_in_word              i_data     = '0;
    logic                  o_valid;
    logic                  i_ready    = 1'b0;
    t_out_word             o_data;

    nearest_neighbor_scale_addresser dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_data     (i_data),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_data     (o_data)
    );

    always #5 i_clk = ~i_clk;

    // local copy of the register file, reset values
    logic [DIM_W-1:0]   src_w    = 13'd1;
    logic [DIM_W-1:0]   src_h    = 13'd1;
    logic [DIM_W-1:0]   dst_w    = 13'd1;
    logic [DIM_W-1:0]   dst_h    = 13'd1;
    logic [PITCH_W-1:0] src_pitch = '0;
    logic [PITCH_W-1:0] dst_pitch = '0;
    logic [ADDR_W-1:0]  src_base = '0;
    logic [ADDR_W-1:0]  dst_base = '0;

    t_in_word   pending_coords[$];
    t_out_word  expected_addrs[$];
    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;
    bit          long_hold_armed = 1'b0;
    bit          hold_done;
    int unsigned hold_left;
    int unsigned idle_cycles;
    int unsigned fail_count = 0;

    // floor(d*src/dst), zero for a zero divisor, clamped to the coordinate range
    function automatic logic [COORD_W-1:0] nearest_source(logic [COORD_W-1:0] d,
                                                          logic [DIM_W-1:0] src,
                                                          logic [DIM_W-1:0] dst);
        logic [PROD_W-1:0] q;
        if (dst == '0) return '0;
        q = (PROD_W'(d) * PROD_W'(src)) / PROD_W'(dst);
        if (q > PROD_W'(COORD_MAX)) return COORD_W'(COORD_MAX);
        return q[COORD_W-1:0];
    endfunction

    function automatic logic [ADDR_W-1:0] pixel_byte_addr(logic [ADDR_W-1:0] base,
                                                          logic [PITCH_W-1:0] pitch,
                                                          logic [COORD_W-1:0] x,
                                                          logic [COORD_W-1:0] y);
        logic [ADDR_W-1:0] words;
        words = ADDR_W'(y) * ADDR_W'(pitch >> 2) + ADDR_W'(x);
        return base + (words << 2);
    endfunction

    function automatic t_out_word map_to_source(t_in_word w);
        t_out_word r;
        r.in_x          = nearest_source(w.out_x, src_w, dst_w);
        r.in_y          = nearest_source(w.out_y, src_h, dst_h);
        r.read_address  = pixel_byte_addr(src_base, src_pitch, r.in_x, r.in_y);
        r.write_address = pixel_byte_addr(dst_base, dst_pitch, w.out_x, w.out_y);
        r.out_of_range  = (DIM_W'(w.out_x) >= dst_w) || (DIM_W'(w.out_y) >= dst_h);
        return r;
    endfunction

    task automatic report_mismatch(string field, logic [ADDR_W-1:0] exp_v,
                                   logic [ADDR_W-1:0] act_v);
        $display("%0t: %s mismatch, expected %h, got %h", $time, field, exp_v, act_v);
        fail_count++;
    endtask

    // driver: next coordinate word once the current one is taken
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || o_ready) begin
            if (pending_coords.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                i_valid <= 1'b1;
                i_data  <= pending_coords.pop_front();
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // receiver stalls, with one long hold-off to back the pipe up
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready   <= 1'b0;
            hold_left <= 0;
            hold_done <= 1'b0;
        end else if (long_hold_armed && !hold_done) begin
            hold_left <= LONG_HOLD;
            hold_done <= 1'b1;
            i_ready   <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            i_ready   <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // monitor: predict on input acceptance, check on output acceptance
    always @(posedge i_clk) begin
        t_out_word exp_w;
        if (i_rst_n) begin
            if (i_valid && o_ready) expected_addrs.push_back(map_to_source(i_data));
            if (o_valid && i_ready) begin
                if (expected_addrs.size() == 0) begin
                    $display("%0t: unexpected word, expected none, got %h", $time, o_data);
                    fail_count++;
                end else begin
                    exp_w = expected_addrs.pop_front();
                    if (o_data.in_x !== exp_w.in_x)
                        report_mismatch("in_x", ADDR_W'(exp_w.in_x),
                                        ADDR_W'(o_data.in_x));
                    if (o_data.in_y !== exp_w.in_y)
                        report_mismatch("in_y", ADDR_W'(exp_w.in_y),
                                        ADDR_W'(o_data.in_y));
                    if (o_data.read_address !== exp_w.read_address)
                        report_mismatch("read_address", exp_w.read_address,
                                        o_data.read_address);
                    if (o_data.write_address !== exp_w.write_address)
                        report_mismatch("write_address", exp_w.write_address,
                                        o_data.write_address);
                    if (o_data.out_of_range !== exp_w.out_of_range)
                        report_mismatch("out_of_range", ADDR_W'(exp_w.out_of_range),
                                        ADDR_W'(o_data.out_of_range));
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("tb: failure");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic write_reg(t_cfg_idx idx, logic [CFG_DATA_W-1:0] val);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        case (idx)
            CFG_SOURCE_WIDTH:  src_w     = val[DIM_W-1:0];
            CFG_SOURCE_HEIGHT: src_h     = val[DIM_W-1:0];
            CFG_TARGET_WIDTH:  dst_w     = val[DIM_W-1:0];
            CFG_TARGET_HEIGHT: dst_h     = val[DIM_W-1:0];
            CFG_SOURCE_PITCH:  src_pitch = val[PITCH_W-1:0];
            CFG_TARGET_PITCH:  dst_pitch = val[PITCH_W-1:0];
            CFG_SOURCE_BASE:   src_base  = val;
            CFG_TARGET_BASE:   dst_base  = val;
            default: ;
        endcase
    endtask

    task automatic apply_setting(int unsigned sw, int unsigned sh, int unsigned tw,
                                 int unsigned th, int unsigned sp, int unsigned tp,
                                 logic [ADDR_W-1:0] sb, logic [ADDR_W-1:0] tb);
        write_reg(CFG_SOURCE_WIDTH,  sw);
        write_reg(CFG_SOURCE_HEIGHT, sh);
        write_reg(CFG_TARGET_WIDTH,  tw);
        write_reg(CFG_TARGET_HEIGHT, th);
        write_reg(CFG_SOURCE_PITCH,  sp);
        write_reg(CFG_TARGET_PITCH,  tp);
        write_reg(CFG_SOURCE_BASE,   sb);
        write_reg(CFG_TARGET_BASE,   tb);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic wait_drained();
        while (pending_coords.size() != 0 || i_valid || expected_addrs.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic queue_coord(int unsigned x, int unsigned y);
        t_in_word w;
        w.out_x = COORD_W'(x);
        w.out_y = COORD_W'(y);
        pending_coords.push_back(w);
    endtask

    // mostly legal sizes, now and then zero, the 13-bit maximum or anything
    function automatic int unsigned pick_size();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 4)  return 0;
        if (r < 8)  return 8191;
        if (r < 12) return $urandom_range(8191);
        if (r < 20) return 4096;
        return $urandom_range(4096, 1);
    endfunction

    // mostly inside the destination, some on the last pixel, some anywhere
    function automatic int unsigned pick_coord(logic [DIM_W-1:0] size);
        int unsigned r;
        int unsigned top;
        r   = $urandom_range(99);
        top = (size > 13'd4096) ? 4096 : size;
        if (size == '0 || r < 10) return $urandom_range(4095);
        if (r < 16) return top - 1;
        return $urandom_range(top - 1);
    endfunction

    task automatic queue_random(int unsigned n);
        for (int unsigned k = 0; k < n; k++)
            queue_coord(pick_coord(dst_w), pick_coord(dst_h));
    endtask

    initial begin
        int unsigned send_mode[4];
        int unsigned recv_mode[4];
        send_mode = '{0, 58, 0, 35};
        recv_mode = '{0, 0, 58, 35};

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset values: unit sizes, so anything but the origin is out of range
        queue_coord(0, 0);
        queue_coord(1, 0);
        queue_coord(4095, 4095);
        wait_drained();

        // upscale, odd pitches (low bits dropped), source base wrapping
        apply_setting(640, 480, 1920, 1080, 2563, 7683, 32'hFFFF_F000, 32'h1000_0000);
        queue_coord(0, 0);
        queue_coord(1919, 1079);
        queue_coord(1920, 1079);
        queue_coord(1919, 1080);
        queue_coord(959, 539);
        queue_coord(12'hAAA, 12'h555);
        queue_coord(12'h555, 12'hAAA);
        queue_coord(4095, 4095);
        wait_drained();

        // zero row divisor, oversized sources saturating, all-ones pitch and base
        apply_setting(8191, 8191, 1, 0, 20'hFFFFF, 20'hFFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        queue_coord(0, 0);
        queue_coord(4095, 4095);
        queue_coord(1, 0);
        queue_coord(2048, 1);
        wait_drained();

        // largest legal destination from a single pixel
        apply_setting(1, 1, 4096, 4096, 3, 4, 0, 0);
        queue_coord(4095, 4095);
        queue_coord(0, 4095);
        queue_coord(4095, 0);
        queue_coord(2047, 2048);
        wait_drained();

        for (int ph = 0; ph < 8; ph++) begin
            apply_setting(pick_size(), pick_size(), pick_size(), pick_size(),
                          $urandom_range(20'hFFFFF), $urandom_range(20'hFFFFF),
                          $urandom, $urandom);
            send_idle_pct  = send_mode[ph % 4];
            recv_stall_pct = recv_mode[ph % 4];
            if (ph == 4) long_hold_armed = 1'b1;
            if (ph == 2) begin
                // sender holds back until the pipe has emptied
                queue_random(ITEMS_PER_PHASE / 2);
                wait_drained();
                queue_random(ITEMS_PER_PHASE - ITEMS_PER_PHASE / 2);
            end else begin
                queue_random(ITEMS_PER_PHASE);
            end
            wait_drained();
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && expected_addrs.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/nnsa_pkg.sv
rtl/nearest_neighbor_scale_addresser.sv
tb/tb_nearest_neighbor_scale_addresser.sv
